### src/isotp_receive_reassembler_macros.svh
// Assertion macros shared by the ISO-TP receive reassembler modules.
`ifndef ISOTP_RECEIVE_REASSEMBLER_MACROS_SVH
`define ISOTP_RECEIVE_REASSEMBLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ISOTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ISOTP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/isotp_pkg.sv
// Shared types and constants of the ISO-TP receive reassembler.
`timescale 1ns / 1ps

package isotp_pkg;

    // Data byte slots carried by one job; one spare slot keeps indexing exact.
    localparam int unsigned ISOTP_SLOTS = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Input operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_FC     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Message status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FRAME   = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ST_BAD_FF_LEN = 3'd3;
    localparam logic [2:0] ST_BAD_CF     = 3'd4;
    localparam logic [2:0] ST_SEQ        = 3'd5;
    localparam logic [2:0] ST_NCR        = 3'd6;
    localparam logic [2:0] ST_BAD_SF_LEN = 3'd7;

    // Protocol control information.
    localparam logic [7:0] PCI_MASK    = 8'hF0;
    localparam logic [7:0] PCI_SINGLE  = 8'h00;
    localparam logic [7:0] PCI_FIRST   = 8'h10;
    localparam logic [7:0] PCI_CONSEC  = 8'h20;
    localparam logic [7:0] FC_CTS      = 8'h30;
    localparam logic [3:0] SF_MAX_LEN  = 4'd7;
    localparam logic [2:0] FF_DATA_LEN = 3'd6;
    localparam logic [2:0] CF_DATA_LEN = 3'd7;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0]  CFG_SEP_TIME   = 2'd1;
    localparam logic [1:0]  CFG_CTO        = 2'd2;
    localparam logic [15:0] CTO_RESET      = 16'd1000;

    // One accepted input beat.
    typedef struct packed {
        logic [1:0]                  operation;
        logic [28:0]                 frame_id;
        logic [ISOTP_SLOTS-1:0][7:0] bytes;
        logic [15:0]                 timeout_ms;
    } item_t;

    // All results caused by one input beat, in compact form.
    typedef struct packed {
        logic [ISOTP_SLOTS-1:0][7:0] data;
        logic [2:0]                  n_bytes;
        logic [11:0]                 base_index;
        logic                        has_fc;
        logic                        has_status;
        logic [2:0]                  status;
        logic [7:0]                  fc_bs;
        logic [7:0]                  fc_st;
        logic [11:0]                 length;
        logic [28:0]                 id;
    } job_t;

    // Head of the job queue as seen by the back end.
    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

endpackage

### src/isotp_receive_reassembler.sv
// Top level of the ISO-TP receive reassembler.
//
//  Channel   Handshake                 Payload
//  input     in_valid / in_ready       operation, frame_id, byte0..byte7, timeout_ms
//  output    out_valid / out_ready     kind, payload_byte, byte_index, fc_byte0..2,
//                                      status, message_length, message_id, last
//  config    cfg_write                 cfg_index, cfg_data
//
// An input beat is decoded and applied to the protocol state in the cycle it is accepted.
// Its results (0 to 8) go to a two-entry job queue and leave the result sequencer one per
// cycle while out_ready does not hold them back.
// in_ready drops only while the job queue is full; the output register decouples out_ready.
// Reset is asynchronous and clears all control state; there is no clearing pass.
`timescale 1ns / 1ps

module isotp_receive_reassembler #(
    parameter int unsigned MAX_MESSAGE_LEN = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [28:0] frame_id,
    input  logic [7:0]  byte0,
    input  logic [7:0]  byte1,
    input  logic [7:0]  byte2,
    input  logic [7:0]  byte3,
    input  logic [7:0]  byte4,
    input  logic [7:0]  byte5,
    input  logic [7:0]  byte6,
    input  logic [7:0]  byte7,
    input  logic [15:0] timeout_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [11:0] byte_index,
    output logic [7:0]  fc_byte0,
    output logic [7:0]  fc_byte1,
    output logic [7:0]  fc_byte2,
    output logic [2:0]  status,
    output logic [11:0] message_length,
    output logic [28:0] message_id,
    output logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import isotp_pkg::*;

    item_t   item;
    job_t    job;
    q_head_t head;
    logic    push;
    logic    pop;
    logic    q_full;

    // Gather the input beat.
    always_comb
    begin
        item.operation  = operation;
        item.frame_id   = frame_id;
        item.bytes[0]   = byte0;
        item.bytes[1]   = byte1;
        item.bytes[2]   = byte2;
        item.bytes[3]   = byte3;
        item.bytes[4]   = byte4;
        item.bytes[5]   = byte5;
        item.bytes[6]   = byte6;
        item.bytes[7]   = byte7;
        item.timeout_ms = timeout_ms;
    end

    isotp_front #(
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .job       (job)
    );

    isotp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    isotp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .fc_byte0       (fc_byte0),
        .fc_byte1       (fc_byte1),
        .fc_byte2       (fc_byte2),
        .status         (status),
        .message_length (message_length),
        .message_id     (message_id),
        .last           (last)
    );

endmodule

### src/isotp_front.sv
// Front end: protocol state, configuration registers and job building.
`timescale 1ns / 1ps

module isotp_front #(
    parameter int unsigned MAX_MESSAGE_LEN = 4095
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  isotp_pkg::item_t     item,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output isotp_pkg::job_t      job
);
    import isotp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_FIRST,
        PH_RECEIVING
    } phase_t;

    localparam logic [11:0] MAX_LEN = 12'(MAX_MESSAGE_LEN);

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [3:0]  seq_reg, seq_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] len_reg, len_next;
    logic [28:0] id_reg, id_next;
    logic [7:0]  bs_reg;
    logic [7:0]  st_reg;
    logic [15:0] cto_reg;

    logic                        accept;
    logic [7:0]                  pci;
    logic [3:0]                  nib;
    logic [11:0]                 ff_len;
    logic [2:0]                  cf_n;
    logic [ISOTP_SLOTS-1:0][7:0] data_from1;
    logic [ISOTP_SLOTS-1:0][7:0] data_from2;
    logic [ISOTP_SLOTS-1:0][7:0] j_data;
    logic [2:0]                  j_n;
    logic [11:0]                 j_base;
    logic                        j_fc;
    logic                        j_st;
    logic [2:0]                  j_status;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Field decode of the frame.
    assign pci    = item.bytes[0] & PCI_MASK;
    assign nib    = item.bytes[0][3:0];
    assign ff_len = {nib, item.bytes[1]};
    assign cf_n   = (rem_reg < 12'(CF_DATA_LEN)) ? rem_reg[2:0] : CF_DATA_LEN;

    // Data bytes aligned for single/consecutive frames and for first frames.
    always_comb
    begin
        for (int i = 0; i < ISOTP_SLOTS; i++)
        begin
            data_from1[i] = (i + 1 < ISOTP_SLOTS) ? item.bytes[(i + 1) % ISOTP_SLOTS] : 8'd0;
            data_from2[i] = (i + 2 < ISOTP_SLOTS) ? item.bytes[(i + 2) % ISOTP_SLOTS] : 8'd0;
        end
    end

    // Next protocol state and the job for this beat.
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        seq_next   = seq_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        j_data     = '0;
        j_n        = '0;
        j_base     = '0;
        j_fc       = 1'b0;
        j_st       = 1'b0;
        j_status   = ST_OK;
        if (accept)
        begin
            case (item.operation)
                OP_START:
                begin
                    phase_next = PH_WAIT_FIRST;
                    wait_next  = item.timeout_ms;
                    id_next    = '0;
                    len_next   = '0;
                    rem_next   = '0;
                    seq_next   = 4'd1;
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (wait_reg <= 16'd1)
                        begin
                            wait_next  = '0;
                            phase_next = PH_IDLE;
                            j_st       = 1'b1;
                            if (phase_reg == PH_WAIT_FIRST)
                            begin
                                len_next = '0;
                                id_next  = '0;
                                j_status = ST_NO_FRAME;
                            end
                            else
                            begin
                                j_status = ST_NCR;
                            end
                        end
                        else
                        begin
                            wait_next = wait_reg - 16'd1;
                        end
                    end
                end
                OP_FRAME:
                begin
                    case (phase_reg)
                        PH_WAIT_FIRST:
                        begin
                            id_next = item.frame_id;
                            if (pci == PCI_SINGLE)
                            begin
                                len_next   = {8'd0, nib};
                                phase_next = PH_IDLE;
                                j_st       = 1'b1;
                                if (nib > SF_MAX_LEN)
                                begin
                                    j_status = ST_BAD_SF_LEN;
                                end
                                else
                                begin
                                    j_data = data_from1;
                                    j_n    = nib[2:0];
                                end
                            end
                            else if (pci == PCI_FIRST)
                            begin
                                len_next = ff_len;
                                if (ff_len <= 12'(FF_DATA_LEN) || ff_len > MAX_LEN)
                                begin
                                    phase_next = PH_IDLE;
                                    j_st       = 1'b1;
                                    j_status   = ST_BAD_FF_LEN;
                                end
                                else
                                begin
                                    j_data     = data_from2;
                                    j_n        = FF_DATA_LEN;
                                    j_fc       = 1'b1;
                                    rem_next   = ff_len - 12'(FF_DATA_LEN);
                                    seq_next   = 4'd1;
                                    wait_next  = cto_reg;
                                    phase_next = PH_RECEIVING;
                                end
                            end
                            else
                            begin
                                len_next   = '0;
                                phase_next = PH_IDLE;
                                j_st       = 1'b1;
                                j_status   = ST_BAD_TYPE;
                            end
                        end
                        PH_RECEIVING:
                        begin
                            if (pci != PCI_CONSEC)
                            begin
                                phase_next = PH_IDLE;
                                j_st       = 1'b1;
                                j_status   = ST_BAD_CF;
                            end
                            else if (nib != seq_reg)
                            begin
                                phase_next = PH_IDLE;
                                j_st       = 1'b1;
                                j_status   = ST_SEQ;
                            end
                            else
                            begin
                                j_data    = data_from1;
                                j_n       = cf_n;
                                j_base    = len_reg - rem_reg;
                                rem_next  = rem_reg - {9'd0, cf_n};
                                seq_next  = seq_reg + 4'd1;
                                wait_next = cto_reg;
                                if (rem_reg == {9'd0, cf_n})
                                begin
                                    phase_next = PH_IDLE;
                                    j_st       = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Every result of a beat carries the message length and id left by that beat.
    always_comb
    begin
        job.data       = j_data;
        job.n_bytes    = j_n;
        job.base_index = j_base;
        job.has_fc     = j_fc;
        job.has_status = j_st;
        job.status     = j_status;
        job.fc_bs      = bs_reg;
        job.fc_st      = st_reg;
        job.length     = len_next;
        job.id         = id_next;
    end

    assign push = accept && (j_n != 3'd0 || j_fc || j_st);

    // Protocol state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            seq_reg   <= 4'd1;
            rem_reg   <= '0;
            len_reg   <= '0;
            id_reg    <= '0;
            bs_reg    <= '0;
            st_reg    <= '0;
            cto_reg   <= CTO_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            seq_reg   <= seq_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BLOCK_SIZE: bs_reg  <= cfg_data[7:0];
                    CFG_SEP_TIME:   st_reg  <= cfg_data[7:0];
                    CFG_CTO:        cto_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

### src/isotp_queue.sv
// Job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`include "isotp_receive_reassembler_macros.svh"

module isotp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  isotp_pkg::job_t      push_job,
    output logic                 full,
    input  logic                 pop,
    output isotp_pkg::q_head_t   head
);
    import isotp_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    // Job storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ISOTP_ASSERT_IMP(a_no_overflow, push, !full, "job pushed into a full queue")
    `ISOTP_ASSERT_IMP(a_no_underflow, pop, head.valid, "job popped from an empty queue")

endmodule

### src/isotp_back.sv
// Back end: expands one job into result beats, one per cycle unless out_ready stalls, into the output register.
`timescale 1ns / 1ps
`include "isotp_receive_reassembler_macros.svh"

module isotp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isotp_pkg::q_head_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [7:0]           payload_byte,
    output logic [11:0]          byte_index,
    output logic [7:0]           fc_byte0,
    output logic [7:0]           fc_byte1,
    output logic [7:0]           fc_byte2,
    output logic [2:0]           status,
    output logic [11:0]          message_length,
    output logic [28:0]          message_id,
    output logic                 last
);
    import isotp_pkg::*;

    logic [2:0]  cnt_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  pb_reg;
    logic [11:0] idx_reg;
    logic [7:0]  fc0_reg;
    logic [7:0]  fc1_reg;
    logic [7:0]  fc2_reg;
    logic [2:0]  status_reg;
    logic [11:0] len_reg;
    logic [28:0] id_reg;
    logic        last_reg;

    logic [3:0]  total;
    logic        load;
    logic        is_last;
    logic [1:0]  kind_next;

    // Result count of the head job and the kind of the beat at the current position.
    assign total   = {1'b0, head.job.n_bytes} + {3'd0, head.job.has_fc}
                   + {3'd0, head.job.has_status};
    assign is_last = ({1'b0, cnt_reg} + 4'd1 == total);
    assign load    = head.valid && (!out_valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        if (cnt_reg < head.job.n_bytes)
        begin
            kind_next = KIND_BYTE;
        end
        else if (head.job.has_fc && cnt_reg == head.job.n_bytes)
        begin
            kind_next = KIND_FC;
        end
        else
        begin
            kind_next = KIND_STATUS;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            pb_reg     <= (kind_next == KIND_BYTE) ? head.job.data[cnt_reg] : 8'd0;
            idx_reg    <= (kind_next == KIND_BYTE) ? head.job.base_index + {9'd0, cnt_reg}
                                                   : 12'd0;
            fc0_reg    <= (kind_next == KIND_FC) ? FC_CTS : 8'd0;
            fc1_reg    <= (kind_next == KIND_FC) ? head.job.fc_bs : 8'd0;
            fc2_reg    <= (kind_next == KIND_FC) ? head.job.fc_st : 8'd0;
            status_reg <= (kind_next == KIND_STATUS) ? head.job.status : ST_OK;
            len_reg    <= head.job.length;
            id_reg     <= head.job.id;
            last_reg   <= is_last;
        end
    end

    // Position within the job and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cnt_reg       <= is_last ? 3'd0 : cnt_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pb_reg;
    assign byte_index     = idx_reg;
    assign fc_byte0       = fc0_reg;
    assign fc_byte1       = fc1_reg;
    assign fc_byte2       = fc2_reg;
    assign status         = status_reg;
    assign message_length = len_reg;
    assign message_id     = id_reg;
    assign last           = last_reg;

    `ISOTP_ASSERT_IMP(a_status_is_last, out_valid_reg && kind_reg == KIND_STATUS, last_reg,
                      "status beat not marked last")
    `ISOTP_ASSERT_IMP(a_cnt_in_job, head.valid, {1'b0, cnt_reg} < total,
                      "result position beyond the head job")

endmodule

### dv/tb.sv
// Self-checking testbench for the ISO-TP receive reassembler, with predictor and scoreboard.
`timescale 1ns / 1ps

module tb;

    import isotp_pkg::*;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_MESSAGE_LEN = 4095;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_SLACK = 16;
    localparam int RANDOM_BEATS = 336;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_WAIT_FIRST,
        RX_RECEIVING
    } rx_phase_t;

    // One input beat; data[0] is the protocol control byte.
    typedef struct packed {
        logic [1:0]      op;
        logic [28:0]     id;
        logic [7:0][7:0] data;
        logic [15:0]     tmo;
    } can_beat_t;

    // One result beat, in port order.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [11:0] byte_index;
        logic [7:0]  fc_byte0;
        logic [7:0]  fc_byte1;
        logic [7:0]  fc_byte2;
        logic [2:0]  status;
        logic [11:0] message_length;
        logic [28:0] message_id;
        logic        last;
    } rx_result_t;

    // Tracks the receiver state, predicts result beats and checks them in order.
    class reassembly_tracker_t;
        logic [7:0]  bs_byte;
        logic [7:0]  sep_time;
        logic [15:0] cto;
        rx_phase_t   phase;
        logic [15:0] wait_ticks;
        logic [3:0]  next_seq;
        logic [11:0] bytes_left;
        logic [11:0] msg_len;
        logic [28:0] msg_id;
        rx_result_t  pending_results[$];
        int          failures;
        int          results_seen;
        int          status_seen[8];

        function new();
            bs_byte = 8'h00;
            sep_time = 8'h00;
            cto = CTO_RESET;
            phase = RX_IDLE;
            wait_ticks = '0;
            next_seq = 4'd1;
            bytes_left = '0;
            msg_len = '0;
            msg_id = '0;
            failures = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_BLOCK_SIZE: bs_byte = value[7:0];
                CFG_SEP_TIME:   sep_time = value[7:0];
                CFG_CTO:        cto = value;
                default:        ;
            endcase
        endfunction

        function void push(logic [1:0] k, logic [7:0] pb, logic [11:0] idx, logic [7:0] f0,
                           logic [7:0] f1, logic [7:0] f2, logic [2:0] st);
            rx_result_t r;
            r = {k, pb, idx, f0, f1, f2, st, msg_len, msg_id, 1'b0};
            pending_results.push_back(r);
        endfunction

        function void close_message(logic [2:0] st);
            phase = RX_IDLE;
            push(KIND_STATUS, 8'h00, 12'h000, 8'h00, 8'h00, 8'h00, st);
        endfunction

        // Applies one accepted beat; returns 1 if the beat mattered to the receiver.
        function bit accept_beat(can_beat_t b);
            int          first;
            logic [11:0] n;
            logic [7:0]  pci;
            first = pending_results.size();
            pci = b.data[0] & PCI_MASK;
            if (b.op == OP_START)
            begin
                phase = RX_WAIT_FIRST;
                wait_ticks = b.tmo;
                msg_id = '0;
                msg_len = '0;
                bytes_left = '0;
                next_seq = 4'd1;
                return 1'b1;
            end
            if (phase == RX_IDLE || (b.op != OP_TICK && b.op != OP_FRAME))
                return 1'b0;

            if (b.op == OP_TICK)
            begin
                // A limit of zero or one runs out on this tick.
                if (wait_ticks <= 16'd1)
                begin
                    wait_ticks = '0;
                    if (phase == RX_WAIT_FIRST)
                    begin
                        msg_len = '0;
                        msg_id = '0;
                        close_message(ST_NO_FRAME);
                    end
                    else
                        close_message(ST_NCR);
                end
                else
                    wait_ticks--;
            end
            else if (phase == RX_WAIT_FIRST)
            begin
                msg_id = b.id;
                if (pci == PCI_SINGLE)
                begin
                    n = {8'h00, b.data[0][3:0]};
                    msg_len = n;
                    if (n > 12'd7)
                        close_message(ST_BAD_SF_LEN);
                    else
                    begin
                        for (int i = 0; i < n; i++)
                            push(KIND_BYTE, b.data[1 + i], 12'(i), 8'h00, 8'h00, 8'h00, ST_OK);
                        close_message(ST_OK);
                    end
                end
                else if (pci == PCI_FIRST)
                begin
                    n = {b.data[0][3:0], b.data[1]};
                    msg_len = n;
                    if (n <= 12'd6 || n > MAX_MESSAGE_LEN)
                        close_message(ST_BAD_FF_LEN);
                    else
                    begin
                        for (int i = 0; i < 6; i++)
                            push(KIND_BYTE, b.data[2 + i], 12'(i), 8'h00, 8'h00, 8'h00, ST_OK);
                        push(KIND_FC, 8'h00, 12'h000, FC_CTS, bs_byte, sep_time, ST_OK);
                        bytes_left = n - 12'd6;
                        next_seq = 4'd1;
                        wait_ticks = cto;
                        phase = RX_RECEIVING;
                    end
                end
                else
                begin
                    msg_len = '0;
                    close_message(ST_BAD_TYPE);
                end
            end
            else
            begin
                // Consecutive frame: type first, then the rolling sequence number.
                if (pci != PCI_CONSEC)
                    close_message(ST_BAD_CF);
                else if (b.data[0][3:0] != next_seq)
                    close_message(ST_SEQ);
                else
                begin
                    n = (bytes_left < 12'd7) ? bytes_left : 12'd7;
                    for (int i = 0; i < n; i++)
                        push(KIND_BYTE, b.data[1 + i], msg_len - bytes_left + 12'(i),
                             8'h00, 8'h00, 8'h00, ST_OK);
                    bytes_left = bytes_left - n;
                    next_seq = next_seq + 4'd1;
                    wait_ticks = cto;
                    if (bytes_left == 12'd0)
                        close_message(ST_OK);
                end
            end
            if (pending_results.size() > first)
                pending_results[pending_results.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        function string describe(rx_result_t r);
            return $sformatf({"kind %0d byte %02h idx %0d fc %02h %02h %02h status %0d ",
                              "len %0d id %08h last %0d"},
                             r.kind, r.payload_byte, r.byte_index, r.fc_byte0, r.fc_byte1,
                             r.fc_byte2, r.status, r.message_length, r.message_id, r.last);
        endfunction

        // Compares one result beat from the block with the oldest prediction.
        function void check_beat(rx_result_t got);
            rx_result_t want;
            bit         bad;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Unexpected result beat: %s", describe(got));
                return;
            end
            want = pending_results.pop_front();
            bad = (got.kind !== want.kind) || (got.payload_byte !== want.payload_byte) ||
                  (got.byte_index !== want.byte_index) || (got.fc_byte0 !== want.fc_byte0) ||
                  (got.fc_byte1 !== want.fc_byte1) || (got.fc_byte2 !== want.fc_byte2) ||
                  (got.status !== want.status) ||
                  (got.message_length !== want.message_length) ||
                  (got.message_id !== want.message_id) || (got.last !== want.last);
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("Result mismatch at %0t", $time);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
            else if (got.kind == KIND_STATUS)
                status_seen[got.status]++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_TICK;
    logic [28:0] frame_id = '0;
    logic [7:0]  byte0 = 8'h00;
    logic [7:0]  byte1 = 8'h00;
    logic [7:0]  byte2 = 8'h00;
    logic [7:0]  byte3 = 8'h00;
    logic [7:0]  byte4 = 8'h00;
    logic [7:0]  byte5 = 8'h00;
    logic [7:0]  byte6 = 8'h00;
    logic [7:0]  byte7 = 8'h00;
    logic [15:0] timeout_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [11:0] byte_index;
    logic [7:0]  fc_byte0;
    logic [7:0]  fc_byte1;
    logic [7:0]  fc_byte2;
    logic [2:0]  status;
    logic [11:0] message_length;
    logic [28:0] message_id;
    logic        last;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_BLOCK_SIZE;
    logic [15:0] cfg_data = '0;

    reassembly_tracker_t rx_model;
    rx_result_t          dut_result;
    int                  burst_left = 0;
    int                  beats_sent = 0;
    int                  beats_acted = 0;
    int                  cycle_count = 0;
    logic [31:0]         rcv_cycle = '0;

    isotp_receive_reassembler #(
        .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .frame_id      (frame_id),
        .byte0         (byte0),
        .byte1         (byte1),
        .byte2         (byte2),
        .byte3         (byte3),
        .byte4         (byte4),
        .byte5         (byte5),
        .byte6         (byte6),
        .byte7         (byte7),
        .timeout_ms    (timeout_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .fc_byte0      (fc_byte0),
        .fc_byte1      (fc_byte1),
        .fc_byte2      (fc_byte2),
        .status        (status),
        .message_length(message_length),
        .message_id    (message_id),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    assign dut_result = {kind, payload_byte, byte_index, fc_byte0, fc_byte1, fc_byte2,
                         status, message_length, message_id, last};

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
                     rx_model.pending_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            rx_model.check_beat(dut_result);
        rcv_cycle = rcv_cycle + 1;
        case (rcv_cycle[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 9) < 7);
            2'd2:    out_ready <= (rcv_cycle[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    function automatic can_beat_t random_beat(logic [1:0] op);
        can_beat_t b;
        b.op = op;
        case ($urandom_range(0, 15))
            0:       b.id = '0;
            1:       b.id = '1;
            default: b.id = 29'($urandom);
        endcase
        for (int i = 0; i < 8; i++)
            b.data[i] = 8'($urandom);
        b.tmo = 16'($urandom);
        return b;
    endfunction

    function automatic can_beat_t frame_beat(logic [7:0] pci_byte);
        can_beat_t b;
        b = random_beat(OP_FRAME);
        b.data[0] = pci_byte;
        return b;
    endfunction

    function automatic can_beat_t first_frame_beat(logic [11:0] len);
        can_beat_t b;
        b = frame_beat(PCI_FIRST | {4'h0, len[11:8]});
        b.data[1] = len[7:0];
        return b;
    endfunction

    // Sender: bursts of beats separated by random gaps.
    task automatic send_beat(can_beat_t b);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= b.op;
        frame_id <= b.id;
        byte0 <= b.data[0];
        byte1 <= b.data[1];
        byte2 <= b.data[2];
        byte3 <= b.data[3];
        byte4 <= b.data[4];
        byte5 <= b.data[5];
        byte6 <= b.data[6];
        byte7 <= b.data[7];
        timeout_ms <= b.tmo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (rx_model.accept_beat(b))
            beats_acted++;
    endtask

    task automatic send_start(logic [15:0] tmo);
        can_beat_t b;
        b = random_beat(OP_START);
        b.tmo = tmo;
        send_beat(b);
    endtask

    task automatic send_tick();
        send_beat(random_beat(OP_TICK));
    endtask

    // Holds the sender until every predicted result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rx_model.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; only called while no results are pending.
    task automatic set_config(logic [7:0] bs, logic [7:0] st, logic [15:0] cto);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data <= {8'h00, bs};
        @(posedge clk);
        rx_model.write_reg(CFG_BLOCK_SIZE, {8'h00, bs});
        cfg_index <= CFG_SEP_TIME;
        cfg_data <= {8'h00, st};
        @(posedge clk);
        rx_model.write_reg(CFG_SEP_TIME, {8'h00, st});
        cfg_index <= CFG_CTO;
        cfg_data <= cto;
        @(posedge clk);
        rx_model.write_reg(CFG_CTO, cto);
        cfg_write <= 1'b0;
    endtask

    // One random message: mostly well formed, with timeouts, errors and aborts mixed in.
    task automatic run_message();
        int          pick;
        int          cfs;
        int          bad_type;
        logic [11:0] len;
        logic [11:0] left;
        logic [3:0]  seq;
        logic [15:0] tmo;
        if ($urandom_range(0, 32) == 0)
            wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            send_beat(random_beat(2'($urandom_range(0, 3))));
            return;
        end

        pick = $urandom_range(0, 19);
        case (pick)
            0:       tmo = 16'h0000;
            1:       tmo = 16'($urandom);
            2:       tmo = 16'hFFFF;
            default: tmo = 16'($urandom_range(1, 6));
        endcase
        send_start(tmo);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) send_tick();

        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // Single frame, now and then with an illegal length.
            len = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(8, 15))
                                              : 12'($urandom_range(0, 7));
            send_beat(frame_beat(PCI_SINGLE | {4'h0, len[3:0]}));
            return;
        end
        if (pick < 38)
        begin
            send_beat(frame_beat({4'($urandom_range(3, 15)), 4'($urandom)}));
            return;
        end

        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 12'($urandom_range(0, 6));
        else if (pick < 16)
            len = 12'($urandom_range(100, 140));
        else if (pick < 20)
            len = ($urandom_range(0, 1) == 0) ? 12'(MAX_MESSAGE_LEN)
                                              : 12'($urandom_range(7, MAX_MESSAGE_LEN));
        else
            len = 12'($urandom_range(7, 48));
        send_beat(first_frame_beat(len));
        if (len < 12'd7)
            return;

        // Consecutive frames; very long messages are abandoned by the next start.
        seq = 4'd1;
        left = len - 12'd6;
        cfs = 0;
        while (left > 0 && cfs < 24)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                bad_type = $urandom_range(0, 14);
                if (bad_type >= 2)
                    bad_type++;
                send_beat(frame_beat({4'(bad_type), 4'($urandom)}));
                return;
            end
            if (pick < 8)
            begin
                send_beat(frame_beat(PCI_CONSEC | {4'h0, seq + 4'($urandom_range(1, 15))}));
                return;
            end
            if (pick < 14)
                repeat ($urandom_range(1, 3)) send_tick();
            else if (pick < 16)
                return;
            send_beat(frame_beat(PCI_CONSEC | {4'h0, seq}));
            seq = seq + 4'd1;
            left = left - ((left < 12'd7) ? left : 12'd7);
            cfs++;
        end
    endtask

    // Main sequence: reset, directed cases, then random phases under different settings.
    initial
    begin
        int        target;
        can_beat_t b;
        rx_model = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(8'h00, 8'hFF, 16'd1);

        // Beats that arrive while idle are dropped.
        send_tick();
        send_beat(random_beat(OP_UNUSED));

        // A zero wait runs out on the first tick.
        send_start(16'h0000);
        send_tick();

        // Empty single frame, then a full one with all bits set.
        send_start(16'hFFFF);
        send_beat(frame_beat(PCI_SINGLE));
        send_start(16'($urandom));
        b = frame_beat(PCI_SINGLE | 8'h07);
        b.id = '1;
        for (int i = 1; i < 8; i++)
            b.data[i] = 8'hFF;
        send_beat(b);

        // Single frame length above seven and first frame length too short.
        send_start(16'hFFFF);
        send_beat(frame_beat(PCI_SINGLE | 8'h0F));
        send_start(16'hFFFF);
        send_beat(first_frame_beat(12'd6));

        // Longest first frame followed by an out-of-order sequence number.
        send_start(16'hFFFF);
        send_beat(first_frame_beat(12'(MAX_MESSAGE_LEN)));
        send_beat(frame_beat(PCI_CONSEC | 8'h02));

        // Shortest segmented message.
        send_start(16'hFFFF);
        b = first_frame_beat(12'd7);
        b.id = '0;
        for (int i = 2; i < 8; i++)
            b.data[i] = 8'h00;
        send_beat(b);
        send_beat(frame_beat(PCI_CONSEC | 8'h01));

        // Wrong frame type in the middle of a message and on the first frame.
        send_start(16'hFFFF);
        send_beat(first_frame_beat(12'd20));
        send_beat(frame_beat(PCI_CONSEC | 8'h01));
        send_beat(frame_beat(FC_CTS));
        send_start(16'hFFFF);
        send_beat(frame_beat(8'hF0));

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0:       set_config(8'hFF, 8'h00, 16'hFFFF);
                1:       set_config(8'($urandom), 8'($urandom), 16'd2);
                2:       set_config(8'($urandom), 8'($urandom), 16'($urandom_range(3, 6)));
                default: set_config(8'h00, 8'hFF, 16'd1);
            endcase
            target = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < target)
                run_message();
        end
        wait_drained();

        $display("Summary: %0d input beats, %0d acted on, %0d result beats checked.",
                 beats_sent, beats_acted, rx_model.results_seen);
        $display({"Message endings: ok %0d, no frame %0d, bad type %0d, bad FF length %0d, ",
                  "bad CF %0d, sequence %0d, N_Cr %0d, bad SF length %0d."},
                 rx_model.status_seen[0], rx_model.status_seen[1], rx_model.status_seen[2],
                 rx_model.status_seen[3], rx_model.status_seen[4], rx_model.status_seen[5],
                 rx_model.status_seen[6], rx_model.status_seen[7]);
        if (rx_model.failures == 0 && rx_model.pending_results.size() == 0)
            $display("tb: PASS");
        else
        begin
            $display("%0d failures, %0d results never arrived.", rx_model.failures,
                     rx_model.pending_results.size());
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/isotp_pkg.sv
src/isotp_front.sv
src/isotp_queue.sv
src/isotp_back.sv
src/isotp_receive_reassembler.sv
dv/tb.sv
